[rtl/bba_pkg.sv]
// ----------------------------------------------------------------------------
// bba_pkg: shared types and constants for the buddy block allocator
// Tree geometry, node codes, payload structs and per-node helper functions.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int TOTAL_BYTES = 256;
    localparam int MIN_BYTES   = 32;
    localparam int LOG_TOTAL   = 8;
    localparam int LEVELS      = 4;
    localparam int NODES       = 15;
    localparam int IDX_W       = 4;

    typedef logic [IDX_W-1:0] node_idx_t;

    // node codes
    typedef enum logic [1:0] {
        NODE_FREE  = 2'd0,
        NODE_SPLIT = 2'd1,
        NODE_OCC   = 2'd2
    } node_state_t;

    // action codes
    localparam logic ACT_ALLOC   = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    // result status codes
    localparam logic [1:0] STATUS_OK          = 2'd0;
    localparam logic [1:0] STATUS_NO_FIT      = 2'd1;
    localparam logic [1:0] STATUS_BAD_RELEASE = 2'd2;

    typedef struct packed {
        logic        action;
        logic [15:0] request_bytes;
        logic [7:0]  release_offset;
    } req_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] block_offset;
        logic [8:0] block_bytes;
    } result_item_t;

    // classified command from front to engine
    typedef struct packed {
        logic       release_op;
        logic       too_big;
        logic [8:0] req_bytes;
        logic [7:0] offset;
    } cmd_t;

    // depth-first, lower-half-first visiting order of the heap indexes
    localparam node_idx_t PREORDER [NODES] = '{
        4'd0, 4'd1, 4'd3, 4'd7, 4'd8, 4'd4, 4'd9, 4'd10,
        4'd2, 4'd5, 4'd11, 4'd12, 4'd6, 4'd13, 4'd14
    };

    function automatic logic [1:0] node_level(input node_idx_t idx);
        logic [1:0] lvl;
        if (idx < 4'd1) begin
            lvl = 2'd0;
        end else if (idx < 4'd3) begin
            lvl = 2'd1;
        end else if (idx < 4'd7) begin
            lvl = 2'd2;
        end else begin
            lvl = 2'd3;
        end
        return lvl;
    endfunction

    function automatic logic [8:0] node_size(input node_idx_t idx);
        logic [9:0] full;
        full = 10'(TOTAL_BYTES);
        return 9'(full >> node_level(idx));
    endfunction

    // offset = rank within level times block size
    function automatic logic [7:0] node_pos(input node_idx_t idx);
        logic [1:0] lvl;
        logic [4:0] rank;
        logic [15:0] wide;
        lvl  = node_level(idx);
        rank = 5'({1'b0, idx} + 5'd1 - (5'd1 << lvl));
        wide = 16'(rank) << (4'(LOG_TOTAL) - 4'(lvl));
        return wide[7:0];
    endfunction

endpackage

[rtl/buddy_block_allocator_core.sv]
// ----------------------------------------------------------------------------
// buddy_block_allocator_core: buddy allocator over a 256-byte region
// Allocates and releases power-of-two blocks of 32 to 256 bytes.
// ----------------------------------------------------------------------------
//  channel   ports                        payload
//  input     s_valid / s_ready / s_item   action, request_bytes, release_offset
//  result    m_valid / m_ready / m_result status, block_offset, block_bytes
//
// For each request the engine scans up to 15 tree nodes in depth-first
// order one per cycle, then splits or merges one level per cycle. Oversized
// allocates skip the scan.
// Reset clears the tree to all free and empties the request queue.
// A two-entry queue keeps taking requests, until full, while the result waits on m_ready.
module buddy_block_allocator_core (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  bba_pkg::req_item_t    s_item,
    output logic                  m_valid,
    input  logic                  m_ready,
    output bba_pkg::result_item_t m_result
);

    logic          cmd_valid;
    logic          cmd_ready;
    bba_pkg::cmd_t cmd;

    bba_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    bba_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_result  (m_result)
    );

endmodule

[rtl/bba_front.sv]
// ----------------------------------------------------------------------------
// bba_front: request intake
// Accepts requests, classifies them and buffers them in a two-entry queue.
// ----------------------------------------------------------------------------
module bba_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  bba_pkg::req_item_t s_item,
    output logic               cmd_valid,
    input  logic               cmd_ready,
    output bba_pkg::cmd_t      cmd
);

    bba_pkg::cmd_t q_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;
    bba_pkg::cmd_t cls;
    logic          push;
    logic          pop;

    // classify: oversized allocates fail without a tree walk
    always_comb begin
        cls.release_op = (s_item.action == bba_pkg::ACT_RELEASE);
        cls.too_big    = (s_item.request_bytes > 16'(bba_pkg::TOTAL_BYTES));
        cls.req_bytes  = s_item.request_bytes[8:0];
        cls.offset     = s_item.release_offset;
    end

    assign s_ready   = (count_reg != 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign push      = s_valid && s_ready;
    assign pop       = cmd_valid && cmd_ready;

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

    // queue pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

[rtl/bba_engine.sv]
// ----------------------------------------------------------------------------
// bba_engine: tree walker
// Holds node states, scans in depth-first order, splits, frees and merges,
// and drives the output register.
// ----------------------------------------------------------------------------
module bba_engine (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cmd_valid,
    output logic                  cmd_ready,
    input  bba_pkg::cmd_t         cmd,
    output logic                  m_valid,
    input  logic                  m_ready,
    output bba_pkg::result_item_t m_result
);

    typedef enum logic [4:0] {
        ENG_IDLE  = 5'b00001,
        ENG_SCAN  = 5'b00010,
        ENG_SPLIT = 5'b00100,
        ENG_MERGE = 5'b01000,
        ENG_DONE  = 5'b10000
    } eng_state_t;

    eng_state_t                state_reg;
    bba_pkg::node_state_t      node_reg [bba_pkg::NODES];
    bba_pkg::cmd_t             cmd_reg;
    bba_pkg::node_idx_t        scan_reg;
    bba_pkg::node_idx_t        cur_reg;
    bba_pkg::result_item_t     res_reg;
    bba_pkg::result_item_t     m_result_reg;
    logic                      m_valid_reg;

    logic [bba_pkg::NODES-1:0] reach;
    logic [bba_pkg::NODES-1:0] fit;
    bba_pkg::node_idx_t        hit_idx;
    logic                      hit;
    logic [8:0]                half;
    logic                      do_split;
    bba_pkg::node_idx_t        lo_idx;
    bba_pkg::node_idx_t        hi_idx;
    bba_pkg::node_idx_t        par_idx;
    bba_pkg::node_idx_t        par_lo;
    bba_pkg::node_idx_t        par_hi;
    logic                      out_free;

    // reachable = every ancestor split; fit per action
    always_comb begin
        for (int i = 0; i < bba_pkg::NODES; i++) begin
            if (i == 0) begin
                reach[i] = 1'b1;
            end else begin
                reach[i] = reach[(i-1)/2] && (node_reg[(i-1)/2] == bba_pkg::NODE_SPLIT);
            end
            if (cmd_reg.release_op) begin
                fit[i] = reach[i] && (node_reg[i] == bba_pkg::NODE_OCC) &&
                         (bba_pkg::node_pos(bba_pkg::node_idx_t'(i)) == cmd_reg.offset);
            end else begin
                fit[i] = reach[i] && (node_reg[i] == bba_pkg::NODE_FREE) &&
                         (bba_pkg::node_size(bba_pkg::node_idx_t'(i)) >= cmd_reg.req_bytes);
            end
        end
    end

    assign hit_idx = bba_pkg::PREORDER[scan_reg];
    assign hit     = fit[hit_idx];

    // split step and merge step indexes
    assign half     = bba_pkg::node_size(cur_reg) >> 1;
    assign do_split = (bba_pkg::node_level(cur_reg) != 2'(bba_pkg::LEVELS - 1)) &&
                      (cmd_reg.req_bytes <= half);
    assign lo_idx   = {cur_reg[2:0], 1'b1};
    assign hi_idx   = {cur_reg[2:0], 1'b0} + 4'd2;
    assign par_idx  = (cur_reg - 4'd1) >> 1;
    assign par_lo   = {par_idx[2:0], 1'b1};
    assign par_hi   = {par_idx[2:0], 1'b0} + 4'd2;
    assign out_free = !m_valid_reg || m_ready;

    assign cmd_ready = (state_reg == ENG_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_result  = m_result_reg;

    // sequencer and tree state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ENG_IDLE;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < bba_pkg::NODES; i++) begin
                node_reg[i] <= bba_pkg::NODE_FREE;
            end
        end else begin
            // result register: load on completion, clear on transfer
            if (state_reg == ENG_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ENG_IDLE: begin
                    if (cmd_valid) begin
                        cmd_reg  <= cmd;
                        scan_reg <= '0;
                        if (!cmd.release_op && cmd.too_big) begin
                            res_reg   <= '{bba_pkg::STATUS_NO_FIT, 8'd0, 9'd0};
                            state_reg <= ENG_DONE;
                        end else begin
                            state_reg <= ENG_SCAN;
                        end
                    end
                end
                ENG_SCAN: begin
                    if (hit) begin
                        cur_reg <= hit_idx;
                        if (cmd_reg.release_op) begin
                            node_reg[hit_idx] <= bba_pkg::NODE_FREE;
                            res_reg <= '{bba_pkg::STATUS_OK, cmd_reg.offset,
                                         bba_pkg::node_size(hit_idx)};
                            state_reg <= ENG_MERGE;
                        end else begin
                            state_reg <= ENG_SPLIT;
                        end
                    end else if (scan_reg == 4'(bba_pkg::NODES - 1)) begin
                        if (cmd_reg.release_op) begin
                            res_reg <= '{bba_pkg::STATUS_BAD_RELEASE, 8'd0, 9'd0};
                        end else begin
                            res_reg <= '{bba_pkg::STATUS_NO_FIT, 8'd0, 9'd0};
                        end
                        state_reg <= ENG_DONE;
                    end else begin
                        scan_reg <= scan_reg + 4'd1;
                    end
                end
                ENG_SPLIT: begin
                    if (do_split) begin
                        node_reg[cur_reg] <= bba_pkg::NODE_SPLIT;
                        node_reg[lo_idx]  <= bba_pkg::NODE_FREE;
                        node_reg[hi_idx]  <= bba_pkg::NODE_FREE;
                        cur_reg           <= lo_idx;
                    end else begin
                        node_reg[cur_reg] <= bba_pkg::NODE_OCC;
                        res_reg <= '{bba_pkg::STATUS_OK, bba_pkg::node_pos(cur_reg),
                                     bba_pkg::node_size(cur_reg)};
                        state_reg <= ENG_DONE;
                    end
                end
                ENG_MERGE: begin
                    if (cur_reg == 4'd0) begin
                        state_reg <= ENG_DONE;
                    end else if (node_reg[par_lo] == bba_pkg::NODE_FREE &&
                                 node_reg[par_hi] == bba_pkg::NODE_FREE) begin
                        node_reg[par_idx] <= bba_pkg::NODE_FREE;
                        cur_reg           <= par_idx;
                    end else begin
                        state_reg <= ENG_DONE;
                    end
                end
                ENG_DONE: begin
                    if (out_free) begin
                        m_result_reg <= res_reg;
                        state_reg    <= ENG_IDLE;
                    end
                end
                default: begin
                    state_reg <= ENG_IDLE;
                end
            endcase
        end
    end

endmodule

[rtl/bba_checker.sv]
// ----------------------------------------------------------------------------
// bba_checker: port-level checks for the buddy allocator
// Watches the result channel and attaches to the top level by bind.
// ----------------------------------------------------------------------------
module bba_checker (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_valid,
    input logic                  m_ready,
    input bba_pkg::result_item_t m_result
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result))
        else $error("result changed while stalled");

    // no result straight out of reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // granted or released block has a real size
    a_ok_size: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result.status == bba_pkg::STATUS_OK |-> m_result.block_bytes != 9'd0)
        else $error("ok result with zero size");

    // failures carry zero fields
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result.status != bba_pkg::STATUS_OK
        |-> m_result.block_bytes == 9'd0 && m_result.block_offset == 8'd0
            && m_result.status != 2'd3)
        else $error("bad failure result");

endmodule

bind buddy_block_allocator_core bba_checker u_bba_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_result (m_result)
);

[sim/buddy_block_allocator_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// buddy_block_allocator_core_tb: self-checking bench for the buddy allocator
// Drives allocate and release requests through the valid/ready input channel.
// A behavioral tree model in the bench predicts each result, and the results
// are compared field by field, in order, under random idling on both sides.
// ----------------------------------------------------------------------------
module buddy_block_allocator_core_tb;

    localparam int TREE_NODES = bba_pkg::NODES;
    localparam int CYCLE_LIMIT = 400000;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    bba_pkg::req_item_t    s_item;
    logic                  m_valid;
    logic                  m_ready;
    bba_pkg::result_item_t m_result;

    buddy_block_allocator_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    // predicted tree and pending results
    bba_pkg::node_state_t  tree_state [TREE_NODES];
    bba_pkg::result_item_t pending_results [$];
    int                    mismatch_count = 0;
    int                    cycle_count = 0;
    int                    send_idle_pct;
    int                    recv_idle_pct;
    logic [7:0]            live_offsets [$];

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // allocate search: depth first, lower half first
    function automatic bit tree_grab(input int idx, input int pos, input int size,
                                     input int req, output int off, output int sz);
        int half;
        half = size / 2;
        off = 0;
        sz = 0;
        if (idx >= TREE_NODES) return 1'b0;
        if (tree_state[idx] == bba_pkg::NODE_FREE) begin
            if (req > size) return 1'b0;
            if (size > bba_pkg::MIN_BYTES && req <= half && 2 * idx + 2 < TREE_NODES) begin
                tree_state[idx] = bba_pkg::NODE_SPLIT;
                tree_state[2 * idx + 1] = bba_pkg::NODE_FREE;
                tree_state[2 * idx + 2] = bba_pkg::NODE_FREE;
                return tree_grab(2 * idx + 1, pos, half, req, off, sz);
            end
            tree_state[idx] = bba_pkg::NODE_OCC;
            off = pos;
            sz = size;
            return 1'b1;
        end
        if (tree_state[idx] == bba_pkg::NODE_SPLIT) begin
            if (tree_grab(2 * idx + 1, pos, half, req, off, sz)) return 1'b1;
            return tree_grab(2 * idx + 2, pos + half, half, req, off, sz);
        end
        return 1'b0;
    endfunction

    // release walk with merge of free buddies on the way back up
    function automatic bit tree_drop(input int idx, input int pos, input int size,
                                     input int at, output int sz);
        int half;
        bit done;
        half = size / 2;
        sz = 0;
        if (idx >= TREE_NODES) return 1'b0;
        if (tree_state[idx] == bba_pkg::NODE_OCC) begin
            if (pos != at) return 1'b0;
            tree_state[idx] = bba_pkg::NODE_FREE;
            sz = size;
            return 1'b1;
        end
        if (tree_state[idx] != bba_pkg::NODE_SPLIT || 2 * idx + 2 >= TREE_NODES) return 1'b0;
        if (at < pos + half) done = tree_drop(2 * idx + 1, pos, half, at, sz);
        else done = tree_drop(2 * idx + 2, pos + half, half, at, sz);
        if (done && tree_state[2 * idx + 1] == bba_pkg::NODE_FREE
                 && tree_state[2 * idx + 2] == bba_pkg::NODE_FREE) begin
            tree_state[idx] = bba_pkg::NODE_FREE;
        end
        return done;
    endfunction

    function automatic bba_pkg::result_item_t predict_result(input bba_pkg::req_item_t item);
        bba_pkg::result_item_t res;
        int off;
        int sz;
        res = '0;
        if (item.action == bba_pkg::ACT_ALLOC) begin
            if (tree_grab(0, 0, bba_pkg::TOTAL_BYTES, int'(item.request_bytes),
                          off, sz)) begin
                res.status = bba_pkg::STATUS_OK;
                res.block_offset = 8'(off);
                res.block_bytes = 9'(sz);
            end else begin
                res.status = bba_pkg::STATUS_NO_FIT;
            end
        end else begin
            if (tree_drop(0, 0, bba_pkg::TOTAL_BYTES, int'(item.release_offset), sz)) begin
                res.status = bba_pkg::STATUS_OK;
                res.block_offset = item.release_offset;
                res.block_bytes = 9'(sz);
            end else begin
                res.status = bba_pkg::STATUS_BAD_RELEASE;
            end
        end
        return res;
    endfunction

    // send one request and record its predicted result on acceptance;
    // valid stays high after the transfer until the next idle or drain
    task automatic send_request(input bba_pkg::req_item_t item);
        bba_pkg::result_item_t res;
        while (($urandom_range(99) < send_idle_pct)) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        res = predict_result(item);
        pending_results.push_back(res);
        if (item.action == bba_pkg::ACT_ALLOC && res.status == bba_pkg::STATUS_OK)
            live_offsets.push_back(res.block_offset);
        if (item.action == bba_pkg::ACT_RELEASE && res.status == bba_pkg::STATUS_OK) begin
            foreach (live_offsets[i]) begin
                if (live_offsets[i] == item.release_offset) begin
                    live_offsets.delete(i);
                    break;
                end
            end
        end
    endtask

    task automatic send_alloc(input int bytes);
        bba_pkg::req_item_t item;
        item.action = bba_pkg::ACT_ALLOC;
        item.request_bytes = 16'(bytes);
        item.release_offset = 8'($urandom);
        send_request(item);
    endtask

    task automatic send_release(input int offset);
        bba_pkg::req_item_t item;
        item.action = bba_pkg::ACT_RELEASE;
        item.request_bytes = 16'($urandom);
        item.release_offset = 8'(offset);
        send_request(item);
    endtask

    // drop valid and wait until every expected result has come
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // result side: random stall, then compare on each transfer
    always @(posedge aclk) begin
        bba_pkg::result_item_t exp_res;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result %p", m_result);
                end else begin
                    exp_res = pending_results.pop_front();
                    if (m_result.status !== exp_res.status
                            || m_result.block_offset !== exp_res.block_offset
                            || m_result.block_bytes !== exp_res.block_bytes) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: expected %p actual %p", exp_res, m_result);
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // directed: extremes of sizes and the special cases
    task automatic test_directed();
        send_alloc(0);
        send_alloc(32);
        send_alloc(33);
        send_alloc(64);
        send_alloc(65535);
        send_alloc(257);
        send_release(16);
        send_release(255);
        send_release(0);
        send_release(0);
        send_release(32);
        send_release(64);
        send_release(128);
        send_alloc(256);
        send_alloc(1);
        send_release(0);
        send_alloc(128);
        send_alloc(128);
        send_alloc(128);
        send_release(128);
        send_release(0);
        send_alloc(31);
        send_alloc(200);
        send_release(0);
        wait_drained();
    endtask

    // random mix: mostly valid alloc and release pairs, some noise
    task automatic test_random(input int count);
        int pick;
        int k;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                case ($urandom_range(3))
                    0: send_alloc($urandom_range(32));
                    1: send_alloc($urandom_range(256));
                    2: send_alloc(1 << $urandom_range(5, 8));
                    default: send_alloc($urandom);
                endcase
            end else if (pick < 85 && live_offsets.size() != 0) begin
                k = $urandom_range(live_offsets.size() - 1);
                send_release(live_offsets[k]);
            end else begin
                send_release($urandom_range(255));
            end
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_item = '0;
        send_idle_pct = 15;
        recv_idle_pct = 72;
        foreach (tree_state[i]) tree_state[i] = bba_pkg::NODE_FREE;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random(140);
        send_idle_pct = 72;
        recv_idle_pct = 15;
        test_random(140);
        // hold off until every result is back
        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(150);

        wait_drained();
        repeat (40) @(posedge aclk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/bba_pkg.sv
rtl/bba_front.sv
rtl/bba_engine.sv
rtl/buddy_block_allocator_core.sv
rtl/bba_checker.sv
sim/buddy_block_allocator_core_tb.sv
